### hw/rtl/moving_mean_skip_missing_defines.svh
// ----------------------------------------------------------------------------
// moving mean assertion macros
// shared concurrent assertion forms for the moving mean block
// ----------------------------------------------------------------------------
`ifndef MOVING_MEAN_SKIP_MISSING_DEFINES_SVH
`define MOVING_MEAN_SKIP_MISSING_DEFINES_SVH

// same-cycle implication
`define MMSM_ASSERT_IMP(label, clk_s, rst_s, pre, post) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |-> (post)) \
    else $error("mmsm assertion failed");

// next-cycle implication
`define MMSM_ASSERT_NXT(label, clk_s, rst_s, pre, post) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |=> (post)) \
    else $error("mmsm assertion failed");

`endif

### hw/rtl/mmsm_pkg.sv
// ----------------------------------------------------------------------------
// mmsm_pkg
// types and fixed constants shared by the moving mean block
// ----------------------------------------------------------------------------
package mmsm_pkg;

  localparam int SPAN_BITS    = 5;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_LEFT_SPAN  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RIGHT_SPAN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_ADD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic neg;
  } div_ctrl_t;

  typedef struct packed {
    logic done;
    logic saturated;
  } div_status_t;

endpackage

### hw/rtl/mmsm_div.sv
// ----------------------------------------------------------------------------
// mmsm_div
// restoring divider, one quotient bit per cycle, signed result with saturation
// ----------------------------------------------------------------------------
module mmsm_div #(
  parameter int NUM_BITS  = 22,
  parameter int FRAC_BITS = 12,
  parameter int DEN_BITS  = 19,
  parameter int OUT_BITS  = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mmsm_pkg::div_ctrl_t        ctrl,
  input  logic [NUM_BITS-1:0]        mag,
  input  logic [DEN_BITS-1:0]        den,
  output mmsm_pkg::div_status_t      status,
  output logic signed [OUT_BITS-1:0] value
);

  localparam int DW       = NUM_BITS + FRAC_BITS;
  localparam int CNT_BITS = $clog2(DW + 1);
  localparam logic [DW-1:0] MAX_POS = DW'((64'd1 << (OUT_BITS - 1)) - 64'd1);
  localparam logic [DW-1:0] MAX_NEG = DW'(64'd1 << (OUT_BITS - 1));

  logic [DW-1:0]       dvd_r, dvd_nxt;
  logic [DW-1:0]       quo_r, quo_nxt;
  logic [DEN_BITS-1:0] rem_r, rem_nxt;
  logic [DEN_BITS-1:0] den_r, den_nxt;
  logic                neg_r, neg_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;

  logic [DEN_BITS:0]   trial;
  logic                fits;
  logic                sat;

  assign trial = {rem_r, dvd_r[DW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctrl.start) begin
      dvd_nxt  = {mag, {FRAC_BITS{1'b0}}};
      quo_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = den;
      neg_nxt  = ctrl.neg;
      cnt_nxt  = CNT_BITS'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the shifted value fits one more bit
      rem_nxt = fits ? DEN_BITS'(trial - {1'b0, den_r}) : DEN_BITS'(trial);
      quo_nxt = {quo_r[DW-2:0], fits};
      dvd_nxt = {dvd_r[DW-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // quotient is a truncated magnitude, sign applied afterwards
  always_comb begin
    sat = neg_r ? (quo_r > MAX_NEG) : (quo_r > MAX_POS);
    if (neg_r) begin
      value = sat ? OUT_BITS'(MAX_NEG) : OUT_BITS'(-quo_r[OUT_BITS-1:0]);
    end else begin
      value = sat ? OUT_BITS'(MAX_POS) : quo_r[OUT_BITS-1:0];
    end
  end

  assign status.done      = done_r;
  assign status.saturated = sat;

endmodule

### hw/rtl/moving_mean_skip_missing.sv
// ----------------------------------------------------------------------------
// moving_mean_skip_missing
// windowed mean over an asymmetric window that skips missing samples
// ----------------------------------------------------------------------------
// One sample is taken per transfer and written into a ring of 2*MAX_SPAN+1
// entries. Results trail the input by right_span samples; a sample marked
// series_end flushes every pending result. While an item is being worked on
// in_stall is high. The window of each result, clipped to the series, is read
// through the single ring read port, each entry passing through ST_READ and
// then ST_ADD, and the quotient comes from one shared restoring divider at one
// bit per cycle. A zero weight sum skips the divider.
// ----------------------------------------------------------------------------
`include "moving_mean_skip_missing_defines.svh"

module moving_mean_skip_missing #(
  parameter int MAX_SPAN         = 16,
  parameter int SAMPLE_BITS      = 16,
  parameter int WEIGHT_FRAC_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [mmsm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [mmsm_pkg::SPAN_BITS-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  input  logic                                in_sample_valid,
  input  logic [WEIGHT_FRAC_BITS:0]           in_weight,
  input  logic                                in_series_end,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_BITS-1:0]       out_mean_value,
  output logic                                out_mean_valid,
  output logic                                out_saturated,
  output logic                                out_last_of_run
);

  localparam int RING_DEPTH  = 2 * MAX_SPAN + 1;
  localparam int PTR_BITS    = $clog2(RING_DEPTH);
  localparam int CW          = $clog2(RING_DEPTH + 1);
  localparam int PW          = $clog2(MAX_SPAN + 2);
  localparam int WEIGHT_BITS = WEIGHT_FRAC_BITS + 1;
  localparam int SUM_BITS    = SAMPLE_BITS + $clog2(RING_DEPTH);
  localparam int WSUM_BITS   = WEIGHT_BITS + $clog2(RING_DEPTH);
  localparam int MEM_W       = 1 + SAMPLE_BITS + WEIGHT_BITS;
  localparam int CMP_W       = mmsm_pkg::SPAN_BITS + CW;

  mmsm_pkg::state_t state_r, state_nxt;

  logic [mmsm_pkg::SPAN_BITS-1:0] left_r, right_r;
  logic [PTR_BITS-1:0]  head_r, head_nxt, head_inc;
  logic [CW-1:0]        pos_r, pos_nxt;
  logic [PW-1:0]        pend_r, pend_nxt;
  logic                 end_r, end_nxt;
  logic [CW-1:0]        j_r, j_nxt;
  logic [CW-1:0]        hi_r, hi_nxt;
  logic                 last_r, last_nxt;
  logic signed [SUM_BITS-1:0] s_acc_r, s_acc_nxt;
  logic [WSUM_BITS-1:0] w_acc_r, w_acc_nxt;
  logic signed [SAMPLE_BITS-1:0] mean_r, mean_nxt;
  logic                 mvalid_r, mvalid_nxt;
  logic                 sat_r, sat_nxt;

  logic [MEM_W-1:0]     ring_mem [RING_DEPTH];
  logic [MEM_W-1:0]     rd_data_r;
  logic [PTR_BITS-1:0]  rd_addr;

  logic [CW-1:0]        l_eff, r_eff;
  logic [CW-1:0]        k, lo, kl, pos_m1, hi;
  logic                 emit_now;
  logic                 in_xfer;
  logic [SAMPLE_BITS-1:0] rd_sample;
  logic [WEIGHT_BITS-1:0] rd_weight;
  logic [SUM_BITS-1:0]  s_mag;

  mmsm_pkg::div_ctrl_t   div_ctrl;
  mmsm_pkg::div_status_t div_stat;
  logic signed [SAMPLE_BITS-1:0] div_value;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= mmsm_pkg::SPAN_BITS'(1);
      right_r <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == mmsm_pkg::CFG_LEFT_SPAN) begin
        left_r <= cfg_data;
      end
      if (cfg_index == mmsm_pkg::CFG_RIGHT_SPAN) begin
        right_r <= cfg_data;
      end
    end
  end

  assign l_eff = (CMP_W'(left_r) > CMP_W'(MAX_SPAN)) ? CW'(MAX_SPAN) : CW'(left_r);
  assign r_eff = (CMP_W'(right_r) > CMP_W'(MAX_SPAN)) ? CW'(MAX_SPAN) : CW'(right_r);

  // ring addressing, entry j counts back from the newest sample
  assign head_inc = (head_r == PTR_BITS'(RING_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign rd_addr  = (CW'(head_r) >= j_r) ?
                    PTR_BITS'(CW'(head_r) - j_r) :
                    PTR_BITS'((CW + 1)'(head_r) + (CW + 1)'(RING_DEPTH) - (CW + 1)'(j_r));

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ring_mem[head_inc] <= {in_sample_valid, in_sample, in_weight};
    end
    rd_data_r <= ring_mem[rd_addr];
  end

  assign rd_sample = rd_data_r[WEIGHT_BITS +: SAMPLE_BITS];
  assign rd_weight = rd_data_r[WEIGHT_BITS-1:0];

  // window bounds for the oldest pending position
  always_comb begin
    k        = CW'(pend_r) - 1'b1;
    lo       = (k >= r_eff) ? k - r_eff : '0;
    kl       = k + l_eff;
    pos_m1   = pos_r - 1'b1;
    hi       = (kl > pos_m1) ? pos_m1 : kl;
    emit_now = end_r ? (pend_r != '0) : (CW'(pend_r) > r_eff);
  end

  assign s_mag = s_acc_r[SUM_BITS-1] ? SUM_BITS'(-s_acc_r) : SUM_BITS'(s_acc_r);

  mmsm_div #(
    .NUM_BITS  (SUM_BITS),
    .FRAC_BITS (WEIGHT_FRAC_BITS),
    .DEN_BITS  (WSUM_BITS),
    .OUT_BITS  (SAMPLE_BITS)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (div_ctrl),
    .mag    (s_mag),
    .den    (w_acc_r),
    .status (div_stat),
    .value  (div_value)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mmsm_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = mmsm_pkg::ST_CHECK;
        end
      end
      mmsm_pkg::ST_CHECK: begin
        state_nxt = emit_now ? mmsm_pkg::ST_READ : mmsm_pkg::ST_IDLE;
      end
      mmsm_pkg::ST_READ: begin
        state_nxt = mmsm_pkg::ST_ADD;
      end
      mmsm_pkg::ST_ADD: begin
        state_nxt = (j_r == hi_r) ? mmsm_pkg::ST_DIV_GO : mmsm_pkg::ST_READ;
      end
      mmsm_pkg::ST_DIV_GO: begin
        state_nxt = (w_acc_r == '0) ? mmsm_pkg::ST_OUT : mmsm_pkg::ST_DIV_WAIT;
      end
      mmsm_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_nxt = mmsm_pkg::ST_OUT;
        end
      end
      mmsm_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_nxt = mmsm_pkg::ST_CHECK;
        end
      end
      default: begin
        state_nxt = mmsm_pkg::ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_stall      = (state_r != mmsm_pkg::ST_IDLE);
    out_valid     = (state_r == mmsm_pkg::ST_OUT);
    div_ctrl.start = (state_r == mmsm_pkg::ST_DIV_GO) && (w_acc_r != '0);
    div_ctrl.neg   = s_acc_r[SUM_BITS-1];
  end

  assign in_xfer = in_valid && !in_stall;

  // datapath next values
  always_comb begin
    head_nxt   = head_r;
    pos_nxt    = pos_r;
    pend_nxt   = pend_r;
    end_nxt    = end_r;
    j_nxt      = j_r;
    hi_nxt     = hi_r;
    last_nxt   = last_r;
    s_acc_nxt  = s_acc_r;
    w_acc_nxt  = w_acc_r;
    mean_nxt   = mean_r;
    mvalid_nxt = mvalid_r;
    sat_nxt    = sat_r;
    case (state_r)
      mmsm_pkg::ST_IDLE: begin
        if (in_xfer) begin
          head_nxt = head_inc;
          pos_nxt  = (pos_r == CW'(RING_DEPTH)) ? pos_r : pos_r + 1'b1;
          pend_nxt = (pend_r == PW'(MAX_SPAN + 1)) ? pend_r : pend_r + 1'b1;
          end_nxt  = in_series_end;
        end
      end
      mmsm_pkg::ST_CHECK: begin
        if (emit_now) begin
          j_nxt     = lo;
          hi_nxt    = hi;
          last_nxt  = end_r && (pend_r == PW'(1));
          s_acc_nxt = '0;
          w_acc_nxt = '0;
        end else if (end_r) begin
          // series done, older ring entries fall outside the clipped window
          pos_nxt = '0;
        end
      end
      mmsm_pkg::ST_ADD: begin
        if (rd_data_r[MEM_W-1]) begin
          s_acc_nxt = s_acc_r +
                      {{(SUM_BITS - SAMPLE_BITS){rd_sample[SAMPLE_BITS-1]}}, rd_sample};
          w_acc_nxt = w_acc_r + WSUM_BITS'(rd_weight);
        end
        if (j_r != hi_r) begin
          j_nxt = j_r + 1'b1;
        end
      end
      mmsm_pkg::ST_DIV_GO: begin
        if (w_acc_r == '0) begin
          mean_nxt   = '0;
          mvalid_nxt = 1'b0;
          sat_nxt    = 1'b0;
        end
      end
      mmsm_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) begin
          mean_nxt   = div_value;
          mvalid_nxt = 1'b1;
          sat_nxt    = div_stat.saturated;
        end
      end
      mmsm_pkg::ST_OUT: begin
        if (!out_stall) begin
          pend_nxt = pend_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    j_r      <= j_nxt;
    hi_r     <= hi_nxt;
    last_r   <= last_nxt;
    s_acc_r  <= s_acc_nxt;
    w_acc_r  <= w_acc_nxt;
    mean_r   <= mean_nxt;
    mvalid_r <= mvalid_nxt;
    sat_r    <= sat_nxt;
    if (!rst_n) begin
      state_r <= mmsm_pkg::ST_IDLE;
      head_r  <= '0;
      pos_r   <= '0;
      pend_r  <= '0;
      end_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      pos_r   <= pos_nxt;
      pend_r  <= pend_nxt;
      end_r   <= end_nxt;
    end
  end

  assign out_mean_value  = mean_r;
  assign out_mean_valid  = mvalid_r;
  assign out_saturated   = sat_r;
  assign out_last_of_run = last_r;

  `MMSM_ASSERT_IMP(a_out_blocks_in, clk, rst_n, out_valid, in_stall)
  `MMSM_ASSERT_IMP(a_pend_bound, clk, rst_n, 1'b1, pend_r <= PW'(MAX_SPAN + 1))
  `MMSM_ASSERT_NXT(a_last_drains, clk, rst_n, out_valid && !out_stall && out_last_of_run, pend_r == '0)
  `MMSM_ASSERT_IMP(a_scan_in_window, clk, rst_n, state_r == mmsm_pkg::ST_ADD, j_r <= hi_r && hi_r < pos_r)

endmodule

### bench/tb_moving_mean_skip_missing.sv
// ----------------------------------------------------------------------------
// tb_moving_mean_skip_missing
// self-checking bench for the windowed mean that skips missing samples
// ----------------------------------------------------------------------------
// Samples are sent over the input channel with random gaps, and results are
// taken with random stalls. A model of the window sums and the divider inside
// the bench predicts every mean, and each result is checked field by field in
// arrival order. Directed series cover the field extremes, zero weight sums,
// saturation, spans above the limit and a span change in mid-series. Random
// series then run under several span settings.
// ----------------------------------------------------------------------------
module tb_moving_mean_skip_missing;

  localparam int MAX_SPAN       = 16;
  localparam int RING_DEPTH     = 2 * MAX_SPAN + 1;
  localparam int FRAC_BITS      = 12;
  localparam int SETTLE_CYCLES  = 16;
  localparam int TAIL_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct {
    logic signed [15:0] value;
    logic               present;
    logic [12:0]        weight;
    logic               closes;
  } reading_t;

  typedef struct {
    logic signed [15:0] value;
    logic               valid;
    logic               sat;
    logic               last;
  } mean_t;

  logic                                clk = 1'b0;
  logic                                rst_n;
  logic                                cfg_wr_en;
  logic [mmsm_pkg::CFG_IDX_BITS-1:0]   cfg_index;
  logic [mmsm_pkg::SPAN_BITS-1:0]      cfg_data;
  logic                                in_valid;
  logic                                in_stall;
  logic signed [15:0]                  in_sample;
  logic                                in_sample_valid;
  logic [12:0]                         in_weight;
  logic                                in_series_end;
  logic                                out_valid;
  logic                                out_stall;
  logic signed [15:0]                  out_mean_value;
  logic                                out_mean_valid;
  logic                                out_saturated;
  logic                                out_last_of_run;

  // window model state
  logic [16:0] sample_hist [RING_DEPTH];
  logic [12:0] weight_hist [RING_DEPTH];
  int          series_len  = 0;
  int          held_count  = 0;
  logic [4:0]  left_reg    = 5'd1;
  logic [4:0]  right_reg   = 5'd0;
  mean_t       due_means[$];

  int mismatches      = 0;
  int in_max_gap      = 4;
  int out_max_wait    = 4;
  int out_hold_cycles = 0;
  int out_stall_left  = 0;
  int idle_cycles     = 0;

  moving_mean_skip_missing DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .in_sample_valid (in_sample_valid),
    .in_weight       (in_weight),
    .in_series_end   (in_series_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_mean_value  (out_mean_value),
    .out_mean_valid  (out_mean_valid),
    .out_saturated   (out_saturated),
    .out_last_of_run (out_last_of_run)
  );

  always #2 clk = ~clk;

  // mean of the valid samples in the window around the entry k steps back
  function automatic mean_t window_mean(input int k, input int l, input int r, input bit last);
    int     lo;
    int     hi;
    longint sum;
    longint wsum;
    longint mag;
    longint quo;
    longint v;
    mean_t  m;
    lo = (k >= r) ? k - r : 0;
    hi = k + l;
    if (hi > series_len - 1) hi = series_len - 1;
    sum  = 0;
    wsum = 0;
    for (int j = lo; j <= hi && j < RING_DEPTH; j++) begin
      if (sample_hist[j][16]) begin
        sum  = sum + longint'($signed(sample_hist[j][15:0]));
        wsum = wsum + longint'(weight_hist[j]);
      end
    end
    m.value = '0;
    m.valid = 1'b0;
    m.sat   = 1'b0;
    m.last  = last;
    if (wsum != 0) begin
      mag = (sum < 0) ? -sum : sum;
      quo = (mag << FRAC_BITS) / wsum;
      if (sum < 0) begin
        if (quo > 32768) begin
          v = -32768;
          m.sat = 1'b1;
        end else begin
          v = -quo;
        end
      end else begin
        if (quo > 32767) begin
          v = 32767;
          m.sat = 1'b1;
        end else begin
          v = quo;
        end
      end
      m.value = v[15:0];
      m.valid = 1'b1;
    end
    return m;
  endfunction

  // shift one accepted sample into the model and queue the means it releases
  function automatic void push_sample(input reading_t rd);
    int l;
    int r;
    l = (left_reg > MAX_SPAN) ? MAX_SPAN : int'(left_reg);
    r = (right_reg > MAX_SPAN) ? MAX_SPAN : int'(right_reg);
    for (int j = RING_DEPTH - 1; j > 0; j--) begin
      sample_hist[j] = sample_hist[j-1];
      weight_hist[j] = weight_hist[j-1];
    end
    sample_hist[0] = {rd.present, rd.value};
    weight_hist[0] = rd.present ? rd.weight : 13'd0;
    if (series_len < RING_DEPTH) series_len++;
    if (held_count < MAX_SPAN + 1) held_count++;
    if (rd.closes) begin
      while (held_count > 0) begin
        due_means.push_back(window_mean(held_count - 1, l, r, held_count == 1));
        held_count--;
      end
      series_len = 0;
    end else begin
      while (held_count > r) begin
        due_means.push_back(window_mean(held_count - 1, l, r, 1'b0));
        held_count--;
      end
    end
  endfunction

  task automatic report_mismatch(input string field, input int want, input int got);
    $display("mean mismatch in %s: expected %0d, got %0d", field, want, got);
    mismatches++;
  endtask

  // result side: random stalls per result, optional long hold-off
  always @(posedge clk) begin : result_check
    mean_t want;
    if (out_valid && !out_stall) begin
      if (due_means.size() == 0) begin
        report_mismatch("unexpected transfer", 0, out_mean_value);
      end else begin
        want = due_means.pop_front();
        if (out_mean_value !== want.value)
          report_mismatch("mean_value", want.value, out_mean_value);
        if (out_mean_valid !== want.valid)
          report_mismatch("mean_valid", want.valid, out_mean_valid);
        if (out_saturated !== want.sat)
          report_mismatch("saturated", want.sat, out_saturated);
        if (out_last_of_run !== want.last)
          report_mismatch("last_of_run", want.last, out_last_of_run);
      end
      out_stall_left = $urandom_range(0, out_max_wait);
    end else if (out_stall_left > 0) begin
      out_stall_left--;
    end
    if (out_hold_cycles > 0) out_hold_cycles--;
    out_stall <= (out_stall_left > 0) || (out_hold_cycles > 0);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_reading(input reading_t rd);
    int gap;
    gap = $urandom_range(0, in_max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample       <= rd.value;
    in_sample_valid <= rd.present;
    in_weight       <= rd.weight;
    in_series_end   <= rd.closes;
    do @(posedge clk); while (in_stall);
    push_sample(rd);
  endtask

  task automatic send_fixed(input int value, input bit present, input int weight, input bit closes);
    reading_t rd;
    rd.value   = 16'(value);
    rd.present = present;
    rd.weight  = 13'(weight);
    rd.closes  = closes;
    send_reading(rd);
  endtask

  // sender pause: nothing offered until every predicted mean has arrived
  task automatic wait_means_drained;
    in_valid <= 1'b0;
    while (due_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_spans(input int l, input int r);
    cfg_wr_en <= 1'b1;
    cfg_index <= mmsm_pkg::CFG_LEFT_SPAN;
    cfg_data  <= mmsm_pkg::SPAN_BITS'(l);
    @(posedge clk);
    left_reg = 5'(l);
    cfg_index <= mmsm_pkg::CFG_RIGHT_SPAN;
    cfg_data  <= mmsm_pkg::SPAN_BITS'(r);
    @(posedge clk);
    right_reg = 5'(r);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic reading_t random_reading(input bit closes, input int missing_pct);
    reading_t rd;
    int       pick;
    rd.present = $urandom_range(0, 99) >= missing_pct;
    if ($urandom_range(0, 1) == 0) rd.value = 16'($urandom);
    else rd.value = 16'($urandom_range(0, 4095)) - 16'd2048;
    pick = $urandom_range(0, 9);
    if (pick == 0) rd.weight = '0;
    else if (pick < 3) rd.weight = 13'($urandom_range(0, 8191));
    else rd.weight = 13'($urandom_range(1, 4096));
    rd.closes = closes;
    return rd;
  endfunction

  task automatic send_series(input int len, input int missing_pct);
    for (int i = 0; i < len; i++) begin
      send_reading(random_reading(i == len - 1, missing_pct));
      if (i == len / 2 && $urandom_range(0, 7) == 0) wait_means_drained();
    end
  endtask

  // reset spans: field extremes, missing samples, zero weight sums, saturation
  task automatic test_default_spans;
    send_fixed(32767, 1'b1, 1, 1'b0);
    send_fixed(-32768, 1'b1, 1, 1'b0);
    send_fixed(-32768, 1'b1, 4096, 1'b0);
    send_fixed(0, 1'b0, 8191, 1'b0);
    send_fixed(-1, 1'b0, 0, 1'b0);
    send_fixed(100, 1'b1, 0, 1'b1);
    // one-sample series right at the negative limit, then just past it
    send_fixed(-32768, 1'b1, 4096, 1'b1);
    send_fixed(-32768, 1'b1, 4095, 1'b1);
    wait_means_drained();
  endtask

  // zero spans, then spans above the limit on a series shorter than the window
  task automatic test_span_limits;
    set_spans(0, 0);
    send_fixed(256, 1'b1, 4096, 1'b0);
    send_fixed(-512, 1'b1, 2048, 1'b1);
    wait_means_drained();
    set_spans(31, 31);
    send_fixed(1000, 1'b1, 4096, 1'b0);
    send_fixed(-300, 1'b1, 8191, 1'b0);
    send_fixed(7, 1'b0, 4096, 1'b0);
    send_fixed(12345, 1'b1, 1, 1'b1);
    wait_means_drained();
  endtask

  // shrinking the right span mid-series releases the held means when the next sample arrives
  task automatic test_span_change;
    set_spans(2, 5);
    for (int i = 0; i < 6; i++) send_fixed(100 * i - 250, 1'b1, 1024 * (i + 1), 1'b0);
    wait_means_drained();
    set_spans(0, 1);
    send_fixed(4000, 1'b1, 4096, 1'b0);
    send_fixed(-4000, 1'b1, 2048, 1'b1);
    wait_means_drained();
  endtask

  // long result hold-off while the sender keeps offering samples
  task automatic test_output_hold;
    set_spans(4, 0);
    in_max_gap      = 0;
    out_max_wait    = 0;
    out_hold_cycles = 400;
    send_series(20, 12);
    wait_means_drained();
  endtask

  task automatic run_random_phase(input int l, input int r, input int idle, input int target);
    int sent;
    int len;
    set_spans(l, r);
    in_max_gap   = idle;
    out_max_wait = idle;
    sent = 0;
    while (sent < target) begin
      len = $urandom_range(1, 40);
      if (len > target - sent) len = target - sent;
      send_series(len, ($urandom_range(0, 9) == 0) ? 100 : 12);
      sent += len;
    end
    wait_means_drained();
  endtask

  task automatic test_random_series;
    run_random_phase(1, 0, 0, 23);
    run_random_phase(16, 16, 4, 23);
    run_random_phase(0, 16, 2, 23);
    run_random_phase(16, 0, 4, 23);
    run_random_phase(5, 3, 4, 23);
    run_random_phase(31, 2, 1, 23);
    run_random_phase(0, 0, 4, 23);
    run_random_phase($urandom_range(0, 31), $urandom_range(0, 31), 4, 23);
  endtask

  initial begin
    for (int j = 0; j < RING_DEPTH; j++) begin
      sample_hist[j] = '0;
      weight_hist[j] = '0;
    end
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_index       = mmsm_pkg::CFG_LEFT_SPAN;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_sample       = '0;
    in_sample_valid = 1'b0;
    in_weight       = '0;
    in_series_end   = 1'b0;
    out_stall       = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_spans();
    test_span_limits();
    test_span_change();
    test_output_hold();
    test_random_series();

    wait_means_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

### moving_mean_skip_missing.f
+incdir+hw/rtl
hw/rtl/mmsm_pkg.sv
hw/rtl/mmsm_div.sv
hw/rtl/moving_mean_skip_missing.sv
bench/tb_moving_mean_skip_missing.sv
